>>> hdl/euler_tour_lca_rmq_defines.svh
// Assertion macros for the euler_tour_lca_rmq checker.
// Depends on nothing; included by the checker file only.
`ifndef EULER_TOUR_LCA_RMQ_DEFINES_SVH
`define EULER_TOUR_LCA_RMQ_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define ETL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset
`define ETL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/etl_pkg.sv
// Shared types and constants for the Euler-tour LCA / range-minimum engine.
// No dependencies; imported by the engine, its compare unit and its checker.
`timescale 1ns / 1ps

package etl_pkg;

  // Field widths fixed by the transaction format
  localparam int DEPTH_W     = 9;
  localparam int NODE_W      = 9;
  localparam int POS_W       = 10;
  localparam int LEN_W       = 11;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - NODE_W;

  // Reset value of the tour length register
  localparam logic [LEN_W-1:0] TOUR_LENGTH_RST = 11'd1024;

  // Operation codes carried in in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_TOUR  = 2'd0,
    OP_FIRST = 2'd1,
    OP_LCA   = 2'd2,
    OP_RMQ   = 2'd3
  } op_t;

endpackage

>>> hdl/etl_cmp.sv
// Shared leftmost-minimum compare unit for the segment tree engine.
// Depends on etl_pkg; one instance serves tree updates and query folds.
`timescale 1ns / 1ps

module etl_cmp
  import etl_pkg::*;
#(
  parameter int PW = 10
) (
  input  logic [DEPTH_W-1:0] a_depth,
  input  logic [PW-1:0]      a_pos,
  input  logic               a_ok,
  input  logic [DEPTH_W-1:0] b_depth,
  input  logic [PW-1:0]      b_pos,
  input  logic               b_ok,
  output logic [DEPTH_W-1:0] y_depth,
  output logic [PW-1:0]      y_pos,
  output logic               y_ok
);

  logic take_b;

  // Operand a is the left one: b wins if a is not valid, or if b is valid with a strictly smaller depth
  assign take_b  = !a_ok || (b_ok && (b_depth < a_depth));
  assign y_depth = take_b ? b_depth : a_depth;
  assign y_pos   = take_b ? b_pos : a_pos;
  assign y_ok    = a_ok || b_ok;

endmodule

>>> hdl/euler_tour_lca_rmq.sv
// Channel  Dir  Handshake              Payload
// in       in   in_tvalid/in_tready    in_tdata (positions, depth, nodes), in_tuser (op)
// out      out  out_tvalid/out_tready  out_tdata (ancestor, min position), out_tuser (empty)
// cfg      in   cfg_we                 cfg_wdata (tour length)
//
// Tour write: the leaf is written, then one segment tree level is folded per cycle through
// the tree memory's one read and one write port and the shared compare unit.
// First-position write: done on acceptance. Queries: S_QFP (LCA only), S_QSET, a bottom-up
// walk of log2(TOUR_LEN) + 1 tree levels reading one node per cycle, then S_QFIN, S_QOUT.
// Reset is synchronous and clears control only; stores hold no state until written.
// in_tready is low while an item is in work; a result waiting on out_tready holds the
// next query in its final cycle, while a new item is still taken ahead of it.
//
// Euler-tour LCA and range-minimum engine: tree memory, node and first-position stores.
// Depends on etl_pkg and etl_cmp.
`timescale 1ns / 1ps

module euler_tour_lca_rmq
  import etl_pkg::*;
#(
  parameter int MAX_NODES = 512,
  parameter int TOUR_LEN  = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: position[9:0], range_end[19:10], depth[28:20], node_id[37:29],
  //           other_node[46:38], zero pad[47]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: op[1:0]
  input  logic [OP_W-1:0]        in_tuser,
  // out_tdata: ancestor[8:0], min_position[18:9], zero pad[23:19]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: empty_res[0]
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [LEN_W-1:0]       cfg_wdata
);

  localparam int PW   = $clog2(TOUR_LEN);
  localparam int NW   = $clog2(MAX_NODES);
  localparam int IW   = PW + 1;
  localparam int RW   = PW + 2;
  localparam int LEAF = 1 << PW;
  localparam int CW   = (LEN_W > PW + 1) ? LEN_W : PW + 1;
  localparam int SEW  = DEPTH_W + PW;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_UPD  = 9'b000000010,
    S_QFP  = 9'b000000100,
    S_QSET = 9'b000001000,
    S_QCHK = 9'b000010000,
    S_QLD  = 9'b000100000,
    S_QRD  = 9'b001000000,
    S_QFIN = 9'b010000000,
    S_QOUT = 9'b100000000
  } state_t;

  // Memories
  logic [SEW-1:0]    seg_mem  [0:2*LEAF-1];
  logic [NODE_W-1:0] node_mem [0:TOUR_LEN-1];
  logic [POS_W-1:0]  fp_mem   [0:MAX_NODES-1];

  // Control registers
  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] tour_length_r;

  // Payload registers
  logic [SEW-1:0]         seg_rdata_r;
  logic [NODE_W-1:0]      node_rdata_r;
  logic [POS_W-1:0]       fp_rdata_a_r, fp_rdata_b_r;
  logic                   fp_ok_a_r, fp_ok_a_nxt, fp_ok_b_r, fp_ok_b_nxt;
  logic                   is_anc_r, is_anc_nxt;
  logic [CW-1:0]          lo_r, lo_nxt, hi_r, hi_nxt;
  logic [RW-1:0]          l_r, l_nxt, r_r, r_nxt;
  logic [DEPTH_W-1:0]     resl_depth_r, resl_depth_nxt, resr_depth_r, resr_depth_nxt;
  logic [PW-1:0]          resl_pos_r, resl_pos_nxt, resr_pos_r, resr_pos_nxt;
  logic                   resl_ok_r, resl_ok_nxt, resr_ok_r, resr_ok_nxt;
  logic [DEPTH_W-1:0]     cur_depth_r, cur_depth_nxt;
  logic [PW-1:0]          cur_pos_r, cur_pos_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [PW-1:0]          fin_pos_r, fin_pos_nxt;
  logic                   fin_empty_r, fin_empty_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tuser_r, out_tuser_nxt;

  // Memory ports
  logic           seg_we;
  logic [IW-1:0]  seg_waddr, seg_raddr;
  logic [SEW-1:0] seg_wdata;
  logic           node_we;
  logic [PW-1:0]  node_raddr;
  logic           fp_we;

  // Input fields
  op_t               in_op;
  logic [POS_W-1:0]  in_position, in_range_end;
  logic [DEPTH_W-1:0] in_depth;
  logic [NODE_W-1:0] in_node_id, in_other_node;
  logic              in_acc;
  logic [31:0]       pos_ext, node_a_ext, node_b_ext;
  logic              pos_ok, node_a_ok, node_b_ok;
  logic [PW-1:0]     pos_idx;
  logic [IW-1:0]     leaf_idx;

  // Compare unit operands
  logic [DEPTH_W-1:0] cmp_a_depth, cmp_b_depth, cmp_y_depth;
  logic [PW-1:0]      cmp_a_pos, cmp_b_pos, cmp_y_pos;
  logic               cmp_a_ok, cmp_b_ok, cmp_y_ok;
  logic [DEPTH_W-1:0] seg_depth;
  logic [PW-1:0]      seg_pos;

  // Unpack the transaction
  assign in_op         = op_t'(in_tuser);
  assign in_position   = in_tdata[9:0];
  assign in_range_end  = in_tdata[19:10];
  assign in_depth      = in_tdata[28:20];
  assign in_node_id    = in_tdata[37:29];
  assign in_other_node = in_tdata[46:38];
  assign in_tready     = (state_r == S_IDLE);
  assign in_acc        = in_tvalid && in_tready;

  assign pos_ext    = 32'(in_position);
  assign node_a_ext = 32'(in_node_id);
  assign node_b_ext = 32'(in_other_node);
  assign pos_ok     = (pos_ext < TOUR_LEN);
  assign node_a_ok  = (node_a_ext < MAX_NODES);
  assign node_b_ok  = (node_b_ext < MAX_NODES);
  assign pos_idx    = pos_ext[PW-1:0];
  assign leaf_idx   = {1'b1, pos_idx};

  assign seg_depth = seg_rdata_r[SEW-1:PW];
  assign seg_pos   = seg_rdata_r[PW-1:0];

  // Route operands to the shared compare unit
  always_comb begin
    cmp_a_depth = resl_depth_r;
    cmp_a_pos   = resl_pos_r;
    cmp_a_ok    = resl_ok_r;
    cmp_b_depth = resr_depth_r;
    cmp_b_pos   = resr_pos_r;
    cmp_b_ok    = resr_ok_r;
    unique case (state_r)
      S_UPD: begin
        cmp_a_ok = 1'b1;
        cmp_b_ok = 1'b1;
        if (!idx_r[0]) begin
          cmp_a_depth = cur_depth_r;
          cmp_a_pos   = cur_pos_r;
          cmp_b_depth = seg_depth;
          cmp_b_pos   = seg_pos;
        end else begin
          cmp_a_depth = seg_depth;
          cmp_a_pos   = seg_pos;
          cmp_b_depth = cur_depth_r;
          cmp_b_pos   = cur_pos_r;
        end
      end
      S_QLD: begin
        cmp_b_depth = seg_depth;
        cmp_b_pos   = seg_pos;
        cmp_b_ok    = 1'b1;
      end
      S_QRD: begin
        cmp_a_depth = seg_depth;
        cmp_a_pos   = seg_pos;
        cmp_a_ok    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  etl_cmp #(
    .PW (PW)
  ) u_cmp (
    .a_depth (cmp_a_depth),
    .a_pos   (cmp_a_pos),
    .a_ok    (cmp_a_ok),
    .b_depth (cmp_b_depth),
    .b_pos   (cmp_b_pos),
    .b_ok    (cmp_b_ok),
    .y_depth (cmp_y_depth),
    .y_pos   (cmp_y_pos),
    .y_ok    (cmp_y_ok)
  );

  // Sequencer
  always_comb begin
    logic [IW-1:0]  parent;
    logic [CW-1:0]  len_ext, n_eff, hi_clip, fa, fb;
    logic           empty;
    logic [RW-1:0]  r_dec;

    state_nxt      = state_r;
    fp_ok_a_nxt    = fp_ok_a_r;
    fp_ok_b_nxt    = fp_ok_b_r;
    is_anc_nxt     = is_anc_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    resl_depth_nxt = resl_depth_r;
    resl_pos_nxt   = resl_pos_r;
    resl_ok_nxt    = resl_ok_r;
    resr_depth_nxt = resr_depth_r;
    resr_pos_nxt   = resr_pos_r;
    resr_ok_nxt    = resr_ok_r;
    cur_depth_nxt  = cur_depth_r;
    cur_pos_nxt    = cur_pos_r;
    idx_nxt        = idx_r;
    fin_pos_nxt    = fin_pos_r;
    fin_empty_nxt  = fin_empty_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    seg_we         = 1'b0;
    seg_waddr      = '0;
    seg_wdata      = '0;
    seg_raddr      = '0;
    node_we        = 1'b0;
    node_raddr     = fin_pos_r;
    fp_we          = 1'b0;

    parent  = idx_r >> 1;
    len_ext = CW'(tour_length_r);
    n_eff   = (len_ext > CW'(TOUR_LEN)) ? CW'(TOUR_LEN) : len_ext;
    empty   = (n_eff == '0) || (lo_r > hi_r) || (lo_r >= n_eff);
    hi_clip = (hi_r >= n_eff) ? (n_eff - CW'(1)) : hi_r;
    fa      = fp_ok_a_r ? CW'(fp_rdata_a_r) : '0;
    fb      = fp_ok_b_r ? CW'(fp_rdata_b_r) : '0;
    r_dec   = r_r - RW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_TOUR: begin
              // Write the leaf and fetch its sibling for the first fold
              if (pos_ok) begin
                seg_we        = 1'b1;
                seg_waddr     = leaf_idx;
                seg_wdata     = {in_depth, pos_idx};
                node_we       = 1'b1;
                cur_depth_nxt = in_depth;
                cur_pos_nxt   = pos_idx;
                idx_nxt       = leaf_idx;
                seg_raddr     = leaf_idx ^ IW'(1);
                state_nxt     = S_UPD;
              end
            end
            OP_FIRST: begin
              fp_we = node_a_ok;
            end
            OP_LCA: begin
              fp_ok_a_nxt = node_a_ok;
              fp_ok_b_nxt = node_b_ok;
              is_anc_nxt  = 1'b1;
              state_nxt   = S_QFP;
            end
            default: begin
              lo_nxt     = CW'(in_position);
              hi_nxt     = CW'(in_range_end);
              is_anc_nxt = 1'b0;
              state_nxt  = S_QSET;
            end
          endcase
        end
      end
      S_UPD: begin
        // Fold one level up the root path
        seg_we        = 1'b1;
        seg_waddr     = parent;
        seg_wdata     = {cmp_y_depth, cmp_y_pos};
        cur_depth_nxt = cmp_y_depth;
        cur_pos_nxt   = cmp_y_pos;
        idx_nxt       = parent;
        if (parent == IW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          seg_raddr = parent ^ IW'(1);
        end
      end
      S_QFP: begin
        // Order the two first positions
        lo_nxt    = (fb < fa) ? fb : fa;
        hi_nxt    = (fb < fa) ? fa : fb;
        state_nxt = S_QSET;
      end
      S_QSET: begin
        if (empty) begin
          fin_empty_nxt = 1'b1;
          fin_pos_nxt   = '0;
          state_nxt     = S_QOUT;
        end else begin
          fin_empty_nxt = 1'b0;
          l_nxt         = RW'(LEAF) + RW'(lo_r);
          r_nxt         = RW'(LEAF) + RW'(hi_clip) + RW'(1);
          resl_ok_nxt   = 1'b0;
          resr_ok_nxt   = 1'b0;
          state_nxt     = S_QCHK;
        end
      end
      S_QCHK: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            seg_raddr = l_r[PW:0];
            l_nxt     = l_r + RW'(1);
            state_nxt = S_QLD;
          end else if (r_r[0]) begin
            seg_raddr = r_dec[PW:0];
            r_nxt     = r_dec;
            state_nxt = S_QRD;
          end else begin
            l_nxt = l_r >> 1;
            r_nxt = r_r >> 1;
          end
        end else begin
          state_nxt = S_QFIN;
        end
      end
      S_QLD: begin
        // Fold a left border node into the left result
        resl_depth_nxt = cmp_y_depth;
        resl_pos_nxt   = cmp_y_pos;
        resl_ok_nxt    = cmp_y_ok;
        if (r_r[0]) begin
          seg_raddr = r_dec[PW:0];
          r_nxt     = r_dec;
          state_nxt = S_QRD;
        end else begin
          l_nxt     = l_r >> 1;
          r_nxt     = r_r >> 1;
          state_nxt = S_QCHK;
        end
      end
      S_QRD: begin
        // Fold a right border node into the right result
        resr_depth_nxt = cmp_y_depth;
        resr_pos_nxt   = cmp_y_pos;
        resr_ok_nxt    = cmp_y_ok;
        l_nxt          = l_r >> 1;
        r_nxt          = r_r >> 1;
        state_nxt      = S_QCHK;
      end
      S_QFIN: begin
        // Join both halves and fetch the node at the winner
        fin_pos_nxt = cmp_y_pos;
        node_raddr  = cmp_y_pos;
        state_nxt   = S_QOUT;
      end
      S_QOUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = fin_empty_r;
          out_tdata_nxt = {{OUT_PAD_W{1'b0}},
                           (fin_empty_r ? {POS_W{1'b0}} : POS_W'(fin_pos_r)),
                           ((is_anc_r && !fin_empty_r) ? node_rdata_r : {NODE_W{1'b0}})};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      tour_length_r <= TOUR_LENGTH_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tour_length_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fp_ok_a_r    <= fp_ok_a_nxt;
    fp_ok_b_r    <= fp_ok_b_nxt;
    is_anc_r     <= is_anc_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    l_r          <= l_nxt;
    r_r          <= r_nxt;
    resl_depth_r <= resl_depth_nxt;
    resl_pos_r   <= resl_pos_nxt;
    resl_ok_r    <= resl_ok_nxt;
    resr_depth_r <= resr_depth_nxt;
    resr_pos_r   <= resr_pos_nxt;
    resr_ok_r    <= resr_ok_nxt;
    cur_depth_r  <= cur_depth_nxt;
    cur_pos_r    <= cur_pos_nxt;
    idx_r        <= idx_nxt;
    fin_pos_r    <= fin_pos_nxt;
    fin_empty_r  <= fin_empty_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  // Segment tree memory: depth and position of each node's leftmost minimum
  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    seg_rdata_r <= seg_mem[seg_raddr];
  end

  // Node id per tour position
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[pos_idx] <= in_node_id;
    end
    node_rdata_r <= node_mem[node_raddr];
  end

  // First tour position per node, two read ports for ancestor queries
  always_ff @(posedge clk) begin
    if (fp_we) begin
      fp_mem[node_a_ext[NW-1:0]] <= in_position;
    end
    fp_rdata_a_r <= fp_mem[node_a_ext[NW-1:0]];
    fp_rdata_b_r <= fp_mem[node_b_ext[NW-1:0]];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> hdl/etl_checker.sv
// Port-level checker for euler_tour_lca_rmq, attached by the bind below.
// Depends on etl_pkg and the assertion macros in euler_tour_lca_rmq_defines.svh.
`timescale 1ns / 1ps
`include "euler_tour_lca_rmq_defines.svh"

module etl_checker
  import etl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OP_W-1:0]        in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  logic in_acc;
  logic is_query;
  logic is_first;

  assign in_acc   = in_tvalid && in_tready;
  assign is_query = (in_tuser == OP_LCA) || (in_tuser == OP_RMQ);
  assign is_first = (in_tuser == OP_FIRST);

  // A query keeps the block busy in the cycle after its transaction
  `ETL_ASSERT_NEXT(a_query_busy, in_acc && is_query, !in_tready, "query did not hold off input")

  // A first-position write completes in its own cycle
  `ETL_ASSERT_NEXT(a_first_one_cycle, in_acc && is_first, in_tready, "first write stalled input")

  // An empty result carries all-zero data
  `ETL_ASSERT_NOW(a_empty_zero, out_tvalid && out_tuser, out_tdata == '0, "empty result not zero")

  // A stalled result holds its data
  `ETL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind euler_tour_lca_rmq etl_checker u_etl_checker (.*);
